// ----- rtl/core/ines_pkg.sv -----
// Package for the cartridge image parser: codes, sizes and shared types.
// No dependencies; every other file of the block imports it.
package ines_pkg;

    localparam int unsigned POS_W = 23;
    localparam int unsigned OFS_W = 22;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};
    localparam logic [POS_W-1:0] HDR_LEN = 23'd16;
    localparam logic [POS_W-1:0] HDR_LAST = 23'd15;
    localparam logic [9:0]       TRAINER_LEN = 10'd512;
    localparam logic [13:0]      PRG_RAM_LEN = 14'd8192;

    localparam logic [7:0] MAGIC_0 = 8'h4E;
    localparam logic [7:0] MAGIC_1 = 8'h45;
    localparam logic [7:0] MAGIC_2 = 8'h53;
    localparam logic [7:0] MAGIC_3 = 8'h1A;

    typedef enum logic [2:0] {
        SEC_HEADER  = 3'd0,
        SEC_TRAINER = 3'd1,
        SEC_PRG     = 3'd2,
        SEC_CHR     = 3'd3,
        SEC_TRAIL   = 3'd4,
        SEC_DISCARD = 3'd5
    } t_section;

    typedef enum logic [1:0] {
        HS_PENDING    = 2'd0,
        HS_VALID      = 2'd1,
        HS_BAD_MAGIC  = 2'd2,
        HS_BAD_REGION = 2'd3
    } t_hdr_status;

    typedef enum logic [1:0] {
        MIR_FOUR  = 2'd0,
        MIR_VERT  = 2'd1,
        MIR_HORIZ = 2'd2
    } t_mirroring;

    typedef enum logic [1:0] {
        REG_NTSC = 2'd0,
        REG_PAL  = 2'd1,
        REG_DUAL = 2'd2
    } t_region;

    typedef logic [15:0][7:0] t_hdr_bytes;

    // Everything the header tells us, plus absolute section boundaries.
    typedef struct packed {
        t_hdr_status      check;
        t_mirroring       mirroring;
        logic [7:0]       mapper_number;
        t_region          region;
        logic [21:0]      chr_ram_bytes;
        logic [13:0]      prg_ram_bytes;
        logic [21:0]      prg_rom_bytes;
        logic [20:0]      chr_rom_bytes;
        logic             has_trainer;
        logic [POS_W-1:0] prg_start;
        logic [POS_W-1:0] chr_start;
        logic [POS_W-1:0] trail_start;
    } t_hdr_info;

endpackage

// ----- rtl/core/ines_if.sv -----
// Channel interfaces of the cartridge image parser: byte input and result output.
// Depends on ines_pkg for the result field types.
interface ines_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rom_byte;
    logic       image_start;

    modport source (output valid, output rom_byte, output image_start, input ready);
    modport sink   (input valid, input rom_byte, input image_start, output ready);
endinterface

interface ines_out_if;
    import ines_pkg::*;

    logic                valid;
    logic                ready;
    t_section            section;
    logic [OFS_W-1:0]    section_offset;
    t_hdr_status         header_status;
    t_mirroring          mirroring;
    logic [7:0]          mapper_number;
    t_region             region;
    logic [21:0]         chr_ram_bytes;
    logic [13:0]         prg_ram_bytes;
    logic [21:0]         prg_rom_bytes;
    logic [20:0]         chr_rom_bytes;
    logic                has_trainer;

    modport source (
        output valid, input ready, output section, output section_offset,
        output header_status, output mirroring, output mapper_number, output region,
        output chr_ram_bytes, output prg_ram_bytes, output prg_rom_bytes,
        output chr_rom_bytes, output has_trainer
    );
    modport sink (
        input valid, output ready, input section, input section_offset,
        input header_status, input mirroring, input mapper_number, input region,
        input chr_ram_bytes, input prg_ram_bytes, input prg_rom_bytes,
        input chr_rom_bytes, input has_trainer
    );
endinterface

// ----- rtl/core/ines_hdr_decode.sv -----
// Combinational decode of the 16 stored header bytes into check result and fields.
// Depends on ines_pkg.
module ines_hdr_decode (
    input  ines_pkg::t_hdr_bytes i_hdr,
    output ines_pkg::t_hdr_info  o_info
);
    import ines_pkg::*;

    logic [9:0]       w_trn;
    logic [POS_W-1:0] w_prg_start;
    logic [POS_W-1:0] w_chr_start;

    assign w_trn       = i_hdr[6][2] ? TRAINER_LEN : 10'd0;
    assign w_prg_start = HDR_LEN + {13'd0, w_trn};
    assign w_chr_start = w_prg_start + {1'b0, i_hdr[4], 14'd0};

    always_comb begin
        if (i_hdr[0] != MAGIC_0 || i_hdr[1] != MAGIC_1 ||
            i_hdr[2] != MAGIC_2 || i_hdr[3] != MAGIC_3) begin
            o_info.check = HS_BAD_MAGIC;
        end else if (i_hdr[10][1] != i_hdr[9][0]) begin
            o_info.check = HS_BAD_REGION;
        end else begin
            o_info.check = HS_VALID;
        end

        if (i_hdr[6][3]) begin
            o_info.mirroring = MIR_FOUR;
        end else if (i_hdr[6][0]) begin
            o_info.mirroring = MIR_VERT;
        end else begin
            o_info.mirroring = MIR_HORIZ;
        end
        // The dual-region flag wins over the PAL flag.
        if (i_hdr[10][0]) begin
            o_info.region = REG_DUAL;
        end else if (i_hdr[9][0]) begin
            o_info.region = REG_PAL;
        end else begin
            o_info.region = REG_NTSC;
        end

        o_info.mapper_number = {i_hdr[7][7:4], i_hdr[6][7:4]};
        o_info.chr_ram_bytes = (i_hdr[5] == 8'd0) ?
                               {({1'b0, i_hdr[8]} + 9'd1), 13'd0} : 22'd0;
        o_info.prg_ram_bytes = i_hdr[6][1] ? PRG_RAM_LEN : 14'd0;
        o_info.prg_rom_bytes = {i_hdr[4], 14'd0};
        o_info.chr_rom_bytes = {i_hdr[5], 13'd0};
        o_info.has_trainer   = i_hdr[6][2];
        o_info.prg_start     = w_prg_start;
        o_info.chr_start     = w_chr_start;
        o_info.trail_start   = w_chr_start + {2'd0, i_hdr[5], 13'd0};
    end

endmodule

// ----- rtl/core/ines_image_parser.sv -----
// Top level of the cartridge image parser: input register, byte classification,
// result register. Depends on ines_pkg, ines_if.sv and ines_hdr_decode.
//
//  channel | dir | payload                                   | handshake
//  i_in    | in  | rom_byte, image_start                     | valid/ready
//  o_out   | out | section, section_offset, header_status,   | valid/ready
//          |     | mirroring ... has_trainer                 |
//
// One byte per cycle unless the result stalls; a byte taken is held in the input
// register, then moved into the result register, which offers its result.
// The byte position, header status and section boundaries live in the second
// stage and are updated as each byte passes it.
// Reset clears the position to zero and the status to pending; header bytes are
// not cleared. A stalled result holds the result register and, behind it, the
// input register; input ready drops only when both are full.
module ines_image_parser (
    input logic       i_clk,
    input logic       i_rst_n,
    ines_in_if.sink   i_in,
    ines_out_if.source o_out
);
    import ines_pkg::*;

    // Input register.
    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_start;

    // Parser state.
    logic [POS_W-1:0] r_pos;
    t_hdr_status      r_status;
    t_hdr_bytes       r_hdr;
    logic [POS_W-1:0] r_prg_start;
    logic [POS_W-1:0] r_chr_start;
    logic [POS_W-1:0] r_trail_start;

    // Result register.
    logic             r_out_valid;
    t_section         r_section;
    logic [OFS_W-1:0] r_offset;
    t_hdr_status      r_out_status;
    t_hdr_info        r_out_info;

    logic             w_advance;
    logic             w_proc;
    logic [POS_W-1:0] w_pos;
    t_hdr_status      w_status_cur;
    t_hdr_status      n_status;
    logic [POS_W-1:0] n_pos;
    t_section         w_section;
    logic [POS_W-1:0] w_base;
    logic [POS_W-1:0] w_diff;
    logic [OFS_W-1:0] w_offset;
    t_hdr_info        w_info;

    ines_hdr_decode u_decode (
        .i_hdr  (r_hdr),
        .o_info (w_info)
    );

    assign w_advance = !r_out_valid || o_out.ready;
    assign w_proc    = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;

    // A start marker rewinds the parser before its byte is handled.
    assign w_pos        = r_start ? '0 : r_pos;
    assign w_status_cur = r_start ? HS_PENDING : r_status;
    assign n_pos        = (w_pos < POS_MAX) ? (w_pos + 23'd1) : w_pos;
    assign n_status     = (w_pos == HDR_LAST) ? w_info.check : w_status_cur;

    always_comb begin
        if (w_pos < HDR_LEN) begin
            w_section = SEC_HEADER;
            w_base    = '0;
        end else if (w_status_cur != HS_VALID) begin
            w_section = SEC_DISCARD;
            w_base    = HDR_LEN;
        end else if (w_pos < r_prg_start) begin
            w_section = SEC_TRAINER;
            w_base    = HDR_LEN;
        end else if (w_pos < r_chr_start) begin
            w_section = SEC_PRG;
            w_base    = r_prg_start;
        end else if (w_pos < r_trail_start) begin
            w_section = SEC_CHR;
            w_base    = r_chr_start;
        end else begin
            w_section = SEC_TRAIL;
            w_base    = r_trail_start;
        end
    end

    assign w_diff   = w_pos - w_base;
    assign w_offset = w_diff[POS_W-1] ? OFS_MAX : w_diff[OFS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_status    <= HS_PENDING;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_proc) begin
                r_pos    <= n_pos;
                r_status <= n_status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte  <= i_in.rom_byte;
            r_start <= i_in.image_start;
        end
        if (w_proc) begin
            if (w_pos < HDR_LEN) begin
                r_hdr[w_pos[3:0]] <= r_byte;
            end
            if (w_pos == HDR_LAST) begin
                r_prg_start   <= w_info.prg_start;
                r_chr_start   <= w_info.chr_start;
                r_trail_start <= w_info.trail_start;
            end
            r_section    <= w_section;
            r_offset     <= w_offset;
            r_out_status <= n_status;
            if (n_status == HS_VALID) begin
                r_out_info <= w_info;
            end else begin
                r_out_info <= '0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.section        = r_section;
    assign o_out.section_offset = r_offset;
    assign o_out.header_status  = r_out_status;
    assign o_out.mirroring      = r_out_info.mirroring;
    assign o_out.mapper_number  = r_out_info.mapper_number;
    assign o_out.region         = r_out_info.region;
    assign o_out.chr_ram_bytes  = r_out_info.chr_ram_bytes;
    assign o_out.prg_ram_bytes  = r_out_info.prg_ram_bytes;
    assign o_out.prg_rom_bytes  = r_out_info.prg_rom_bytes;
    assign o_out.chr_rom_bytes  = r_out_info.chr_rom_bytes;
    assign o_out.has_trainer    = r_out_info.has_trainer;

    // Payload sections only exist behind an accepted header.
    a_sections_need_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_section == SEC_TRAINER || r_section == SEC_PRG ||
                         r_section == SEC_CHR || r_section == SEC_TRAIL))
        |-> (r_out_status == HS_VALID))
        else $error("payload section reported without a valid header");

    // Before the last header byte the header cannot have been judged.
    a_header_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_section == SEC_HEADER && r_offset != 22'd15)
        |-> (r_out_status == HS_PENDING))
        else $error("header status decided before the last header byte");

    // Decoded fields stay zero unless the header was accepted.
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != HS_VALID)
        |-> (r_out_info.prg_rom_bytes == 22'd0 && r_out_info.mapper_number == 8'd0 &&
             r_out_info.chr_ram_bytes == 22'd0))
        else $error("decoded fields leaked from a header that is not valid");

    // Rejected headers send every later byte to the discard section.
    a_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_section != SEC_HEADER &&
         (r_out_status == HS_BAD_MAGIC || r_out_status == HS_BAD_REGION))
        |-> (r_section == SEC_DISCARD))
        else $error("byte after a rejected header not discarded");

endmodule
